/* sv/fcc_pkg.sv */
// Shared types, codes and constants of the cluster chain engine.
package fcc_pkg;

  localparam int FCC_TABLE_ENTRIES = 65536;
  localparam int FCC_MAX_CHAIN     = 64;

  localparam logic [27:0] END_MARK      = 28'hFFFFFFF;
  localparam logic [27:0] CHAIN_END_MIN = 28'hFFFFFF8;
  localparam logic [16:0] LIMIT_RESET   = 17'd65536;

  // Request modes
  localparam logic [1:0] MODE_NEXT  = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_ALLOC = 2'd2;
  localparam logic [1:0] MODE_LOAD  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_LOOP    = 2'd3;

  // Datapath commands
  localparam logic [3:0] CMD_NONE         = 4'd0;
  localparam logic [3:0] CMD_CLEAR        = 4'd1;
  localparam logic [3:0] CMD_LATCH        = 4'd2;
  localparam logic [3:0] CMD_NEXT_RD      = 4'd3;
  localparam logic [3:0] CMD_EMIT_BAD     = 4'd4;
  localparam logic [3:0] CMD_EMIT_NEXT    = 4'd5;
  localparam logic [3:0] CMD_LOAD         = 4'd6;
  localparam logic [3:0] CMD_FREE_RD      = 4'd7;
  localparam logic [3:0] CMD_FREE_WR      = 4'd8;
  localparam logic [3:0] CMD_EMIT_FREE    = 4'd9;
  localparam logic [3:0] CMD_SCAN_INIT    = 4'd10;
  localparam logic [3:0] CMD_SCAN         = 4'd11;
  localparam logic [3:0] CMD_EMIT_NOSPACE = 4'd12;
  localparam logic [3:0] CMD_LK_RD        = 4'd13;
  localparam logic [3:0] CMD_LK_FIRST     = 4'd14;
  localparam logic [3:0] CMD_LK_W         = 4'd15;

  typedef struct packed {
    logic [1:0]  mode;
    logic [27:0] cluster;
    logic [6:0]  chain_count;
    logic [27:0] entry_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [27:0] cluster_out;
    logic [16:0] freed_count;
    logic        last;
  } out_word_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic [1:0] mode;
    logic       cur_ge_lim;
    logic       cnt_bad;
    logic       walk_end;
    logic       walk_loop;
    logic       scan_ok;
    logic       scan_fail;
    logic       idx_zero;
    logic       idx_end;
    logic       clear_done;
    logic       out_free;
  } fcc_stat_t;

endpackage

/* sv/fcc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fcc_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* sv/fcc_dp.sv */
// Datapath: cluster table, gather list, walk and scan counters, result register.
module fcc_dp
  import fcc_pkg::*;
#(
  parameter int TABLE_ENTRIES = FCC_TABLE_ENTRIES,
  parameter int MAX_CHAIN     = FCC_MAX_CHAIN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] cmd,
  input  in_word_t   in_data,
  input  logic [16:0] limit,
  input  logic       out_stall,
  output logic       out_valid,
  output out_word_t  out_data,
  output fcc_stat_t  stat
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int FW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;

  logic [27:0]   cur_r, cur_nxt;
  logic [AW:0]   freed_r, freed_nxt;
  logic [6:0]    found_r, found_nxt;
  logic [6:0]    idx_r, idx_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [27:0]   val_r, val_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [AW-1:0] pa_r, pa_nxt;
  logic          pv_r, pv_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_data_r, out_data_nxt;

  logic          tab_we, tab_re;
  logic [AW-1:0] tab_waddr;
  logic [27:0]   tab_wdata, tab_rdata;
  logic          fl_we, fl_re;
  logic [FW-1:0] fl_waddr, fl_raddr;
  logic [27:0]   fl_wdata, fl_rdata;

  logic [28:0] lim;
  logic        hit, issue, emit;
  out_word_t   res;
  logic [1:0]  free_st;

  // Cap the programmed limit at the table size
  assign lim = (29'(limit) > 29'(TABLE_ENTRIES)) ? 29'(TABLE_ENTRIES) : 29'(limit);

  assign hit   = pv_r && (tab_rdata == 28'd0);
  assign issue = ({1'b0, cur_r} < lim);

  assign free_st = stat.walk_end ? ST_OK : (stat.cur_ge_lim ? ST_BAD : ST_LOOP);

  // Status toward the controller
  always_comb begin
    stat.mode       = mode_r;
    stat.cur_ge_lim = ({1'b0, cur_r} >= lim);
    stat.cnt_bad    = (cnt_r == 7'd0) || (cnt_r > 7'(MAX_CHAIN));
    stat.walk_end   = (cur_r < 28'd2) || (cur_r >= CHAIN_END_MIN);
    stat.walk_loop  = (29'(freed_r) >= lim);
    stat.scan_ok    = ((found_r + 7'(hit)) == cnt_r);
    stat.scan_fail  = !pv_r && ({1'b0, cur_r} >= lim);
    stat.idx_zero   = (idx_r == 7'd0);
    stat.idx_end    = (idx_r == cnt_r);
    stat.clear_done = (clr_r == {AW{1'b1}});
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // Decode the command
  always_comb begin
    cur_nxt   = cur_r;
    freed_nxt = freed_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    mode_nxt  = mode_r;
    pa_nxt    = pa_r;
    pv_nxt    = pv_r;
    clr_nxt   = clr_r;
    tab_we    = 1'b0;
    tab_re    = 1'b0;
    tab_waddr = cur_r[AW-1:0];
    tab_wdata = 28'd0;
    fl_we     = 1'b0;
    fl_re     = 1'b0;
    fl_waddr  = found_r[FW-1:0];
    fl_wdata  = {{(28-AW){1'b0}}, pa_r};
    fl_raddr  = idx_r[FW-1:0];
    emit      = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    case (cmd)
      CMD_CLEAR: begin
        tab_we    = 1'b1;
        tab_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
      end
      CMD_LATCH: begin
        mode_nxt  = in_data.mode;
        cur_nxt   = in_data.cluster;
        cnt_nxt   = in_data.chain_count;
        val_nxt   = in_data.entry_value;
        freed_nxt = '0;
      end
      CMD_NEXT_RD, CMD_FREE_RD: begin
        tab_re = 1'b1;
      end
      CMD_EMIT_BAD: begin
        emit       = 1'b1;
        res.status = ST_BAD;
      end
      CMD_EMIT_NEXT: begin
        emit            = 1'b1;
        res.cluster_out = tab_rdata;
      end
      CMD_LOAD: begin
        tab_we          = 1'b1;
        tab_wdata       = val_r;
        emit            = 1'b1;
        res.cluster_out = val_r;
      end
      CMD_FREE_WR: begin
        tab_we    = 1'b1;
        freed_nxt = freed_r + 1'b1;
        cur_nxt   = tab_rdata;
      end
      CMD_EMIT_FREE: begin
        emit            = 1'b1;
        res.status      = free_st;
        res.freed_count = 17'(freed_r);
      end
      CMD_SCAN_INIT: begin
        cur_nxt   = 28'd2;
        found_nxt = '0;
        idx_nxt   = '0;
        pv_nxt    = 1'b0;
      end
      CMD_SCAN: begin
        // record a free entry from the last read, issue the next read
        if (hit) begin
          fl_we     = 1'b1;
          found_nxt = found_r + 1'b1;
        end
        tab_re = issue;
        pv_nxt = issue;
        pa_nxt = cur_r[AW-1:0];
        if (issue) begin
          cur_nxt = cur_r + 1'b1;
        end
      end
      CMD_EMIT_NOSPACE: begin
        emit       = 1'b1;
        res.status = ST_NOSPACE;
      end
      CMD_LK_RD: begin
        fl_re = !stat.idx_end;
      end
      CMD_LK_FIRST: begin
        cur_nxt = fl_rdata;
        idx_nxt = 7'd1;
      end
      CMD_LK_W: begin
        // link previous cluster to the next one, or end the chain
        tab_we          = 1'b1;
        tab_wdata       = stat.idx_end ? END_MARK : fl_rdata;
        emit            = 1'b1;
        res.cluster_out = cur_r;
        res.last        = stat.idx_end;
        cur_nxt         = fl_rdata;
        idx_nxt         = idx_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_data_nxt  = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    freed_r    <= freed_nxt;
    found_r    <= found_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    val_r      <= val_nxt;
    mode_r     <= mode_nxt;
    pa_r       <= pa_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fcc_ram #(.WIDTH(28), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (tab_waddr),
    .wdata   (tab_wdata),
    .re      (tab_re),
    .raddr   (cur_r[AW-1:0]),
    .rdata_r (tab_rdata)
  );

  fcc_ram #(.WIDTH(28), .DEPTH(MAX_CHAIN)) u_found (
    .clk     (clk),
    .we      (fl_we),
    .waddr   (fl_waddr),
    .wdata   (fl_wdata),
    .re      (fl_re),
    .raddr   (fl_raddr),
    .rdata_r (fl_rdata)
  );

endmodule

/* sv/fcc_ctrl.sv */
// Controller: request sequencing state machine.
module fcc_ctrl
  import fcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  fcc_stat_t stat,
  output logic [3:0] cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_NEXT  = 4'd3;
  localparam logic [3:0] S_FCHK  = 4'd4;
  localparam logic [3:0] S_FWR   = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_LKRD  = 4'd7;
  localparam logic [3:0] S_LKW   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd = CMD_CLEAR;
        if (stat.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.out_free) begin
          case (stat.mode)
            MODE_NEXT: begin
              cmd       = stat.cur_ge_lim ? CMD_EMIT_BAD : CMD_NEXT_RD;
              state_nxt = stat.cur_ge_lim ? S_IDLE : S_NEXT;
            end
            MODE_LOAD: begin
              cmd       = stat.cur_ge_lim ? CMD_EMIT_BAD : CMD_LOAD;
              state_nxt = S_IDLE;
            end
            MODE_FREE: begin
              state_nxt = S_FCHK;
            end
            default: begin
              cmd       = stat.cnt_bad ? CMD_EMIT_BAD : CMD_SCAN_INIT;
              state_nxt = stat.cnt_bad ? S_IDLE : S_SCAN;
            end
          endcase
        end
      end
      S_NEXT: begin
        if (stat.out_free) begin
          cmd       = CMD_EMIT_NEXT;
          state_nxt = S_IDLE;
        end
      end
      S_FCHK: begin
        // stop the walk at chain end, table edge or loop
        if (stat.walk_end || stat.cur_ge_lim || stat.walk_loop) begin
          if (stat.out_free) begin
            cmd       = CMD_EMIT_FREE;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd       = CMD_FREE_RD;
          state_nxt = S_FWR;
        end
      end
      S_FWR: begin
        cmd       = CMD_FREE_WR;
        state_nxt = S_FCHK;
      end
      S_SCAN: begin
        if (stat.scan_ok) begin
          cmd       = CMD_SCAN;
          state_nxt = S_LKRD;
        end else if (stat.scan_fail) begin
          if (stat.out_free) begin
            cmd       = CMD_EMIT_NOSPACE;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd = CMD_SCAN;
        end
      end
      S_LKRD: begin
        cmd       = CMD_LK_RD;
        state_nxt = S_LKW;
      end
      S_LKW: begin
        if (stat.idx_zero) begin
          cmd       = CMD_LK_FIRST;
          state_nxt = S_LKRD;
        end else if (stat.out_free) begin
          cmd       = CMD_LK_W;
          state_nxt = stat.idx_end ? S_IDLE : S_LKRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/fat_cluster_chain_engine.sv */
// Cluster chain engine: a FAT32 cluster table in internal RAM serving next lookup,
// chain free, chain allocate and entry load requests, one request at a time.
// After reset the block clears the table, one entry a cycle, and stalls input words
// until done. A free request reads each entry of the chain and then clears it
// through the table RAM port; an allocation scans one entry per cycle from
// cluster 2 until enough free entries are found or the limit is reached, then
// links and emits the found clusters one by one through the gather list RAM.
// cluster_limit is written at byte addresses 0 to 3 over the APB port; the user
// must write it only while the block is idle, which the block does not enforce.
module fat_cluster_chain_engine
  import fcc_pkg::*;
#(
  parameter int TABLE_ENTRIES = FCC_TABLE_ENTRIES,
  parameter int MAX_CHAIN     = FCC_MAX_CHAIN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [16:0] limit_r, limit_nxt;
  logic [3:0]  cmd;
  fcc_stat_t   stat;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {15'd0, limit_r};

  // Take register writes
  always_comb begin
    limit_nxt = limit_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      limit_nxt = cfg_pwdata[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  fcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CHAIN     (MAX_CHAIN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .limit     (limit_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule

/* test/fat_cluster_chain_checker.sv */
// Checker of the cluster chain engine: mirrors the table, predicts results, compares.
module fat_cluster_chain_checker
  import fcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending,
  output int          words_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [27:0] fat_mirror [0:FCC_TABLE_ENTRIES-1];
  logic [16:0] limit_reg;
  out_word_t   expected_words[$];

  initial begin
    for (int i = 0; i < FCC_TABLE_ENTRIES; i++) fat_mirror[i] = '0;
    limit_reg  = LIMIT_RESET;
    mismatches = 0;
    words_seen = 0;
  end

  assign pending = expected_words.size();

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic out_word_t mk(logic [1:0] st, logic [27:0] cl, logic [16:0] fr,
                                   logic lst);
    out_word_t w;
    w.status = st;
    w.cluster_out = cl;
    w.freed_count = fr;
    w.last = lst;
    return w;
  endfunction

  // Work out the result words of one request and update the mirrored table
  task automatic predict_request(input in_word_t req);
    int unsigned lim;
    logic [27:0] c, nxt;
    int unsigned freed;
    logic [1:0]  st;
    int unsigned found;
    logic [27:0] picked [0:FCC_MAX_CHAIN-1];
    lim = (limit_reg > FCC_TABLE_ENTRIES) ? FCC_TABLE_ENTRIES : limit_reg;
    case (req.mode)
      MODE_NEXT: begin
        if (req.cluster >= lim) expected_words.push_back(mk(ST_BAD, '0, '0, 1'b1));
        else expected_words.push_back(mk(ST_OK, fat_mirror[req.cluster], '0, 1'b1));
      end
      MODE_LOAD: begin
        if (req.cluster >= lim) expected_words.push_back(mk(ST_BAD, '0, '0, 1'b1));
        else begin
          fat_mirror[req.cluster] = req.entry_value;
          expected_words.push_back(mk(ST_OK, req.entry_value, '0, 1'b1));
        end
      end
      MODE_FREE: begin
        freed = 0;
        st = ST_OK;
        c = req.cluster;
        while (c >= 2 && c < CHAIN_END_MIN) begin
          if (c >= lim) begin
            st = ST_BAD;
            break;
          end
          if (freed >= lim) begin
            st = ST_LOOP;
            break;
          end
          nxt = fat_mirror[c];
          fat_mirror[c] = '0;
          freed++;
          c = nxt;
        end
        expected_words.push_back(mk(st, '0, freed[16:0], 1'b1));
      end
      default: begin
        if (req.chain_count == 0 || req.chain_count > FCC_MAX_CHAIN) begin
          expected_words.push_back(mk(ST_BAD, '0, '0, 1'b1));
        end else begin
          found = 0;
          for (int unsigned k = 2; k < lim && found < req.chain_count; k++)
            if (fat_mirror[k] == '0) begin
              picked[found] = k[27:0];
              found++;
            end
          if (found < req.chain_count) begin
            expected_words.push_back(mk(ST_NOSPACE, '0, '0, 1'b1));
          end else begin
            // Link in ascending order, end mark on the tail
            for (int i = 0; i < req.chain_count; i++) begin
              fat_mirror[picked[i]] = (i + 1 < req.chain_count) ? picked[i+1] : END_MARK;
              expected_words.push_back(mk(ST_OK, picked[i], '0, i + 1 == req.chain_count));
            end
          end
        end
      end
    endcase
  endtask

  // Watch the channels and the register port on every edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 3'd0)
        limit_reg = cfg_pwdata[16:0];
      if (in_valid && !in_stall) predict_request(in_data);
      if (out_valid && !out_stall) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          report($sformatf("unexpected word %h", out_data));
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          if (out_data.status !== e.status)
            report($sformatf("status %0d, want %0d", out_data.status, e.status));
          if (out_data.cluster_out !== e.cluster_out)
            report($sformatf("cluster_out %h, want %h", out_data.cluster_out, e.cluster_out));
          if (out_data.freed_count !== e.freed_count)
            report($sformatf("freed_count %0d, want %0d", out_data.freed_count,
                             e.freed_count));
          if (out_data.last !== e.last)
            report($sformatf("last %0b, want %0b", out_data.last, e.last));
        end
      end
    end
  end

endmodule

/* test/fat_cluster_chain_engine_tb.sv */
// Testbench top of the cluster chain engine: clock, reset, stimulus and verdict.
module fat_cluster_chain_engine_tb;
  import fcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches, pending, words_seen;
  int requests_sent = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit no_idle = 1'b0;
  int unsigned cur_limit = 65536;

  fat_cluster_chain_engine dut (.*);

  fat_cluster_chain_checker checker_i (.*);

  initial forever #2 clk = ~clk;

  // Guard against a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stall: random, or a long counted hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 21);
    end
  end

  // Offer one request word and hold it until accepted
  task automatic send_request(input logic [1:0] md, input logic [27:0] cl,
                              input logic [6:0] cnt, input logic [27:0] val);
    in_word_t w;
    w.mode = md;
    w.cluster = cl;
    w.chain_count = cnt;
    w.entry_value = val;
    while (!no_idle && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write one register through the APB port; block must be idle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    drain();
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == 3'd0) cur_limit = (value[16:0] > 65536) ? 65536 : value[16:0];
  endtask

  // Random request, mostly inside the active table
  task automatic send_random();
    logic [1:0]  md;
    logic [27:0] cl, val;
    logic [6:0]  cnt;
    int unsigned r;
    md = 2'($urandom_range(3));
    r = $urandom_range(99);
    if (r < 85) cl = 28'($urandom_range(cur_limit + 2));
    else cl = 28'($urandom);
    r = $urandom_range(99);
    if (r < 85) cnt = 7'($urandom_range(1, (cur_limit < 64) ? 4 : 12));
    else cnt = 7'($urandom_range(127));
    r = $urandom_range(99);
    if (r < 50) val = 28'($urandom_range(2, cur_limit + 1));
    else if (r < 70) val = 28'($urandom_range(28'hFFFFFFF, 28'hFFFFFF8));
    else val = 28'($urandom);
    send_request(md, cl, cnt, val);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: edges of the fields and every special case at full size
    send_request(MODE_NEXT, 28'd0, 7'd0, 28'd0);
    send_request(MODE_NEXT, 28'd65535, 7'd0, 28'd0);
    send_request(MODE_NEXT, 28'd65536, 7'd0, 28'd0);
    send_request(MODE_NEXT, 28'hFFFFFFF, 7'd127, 28'hFFFFFFF);
    send_request(MODE_LOAD, 28'd5, 7'd0, 28'hFFFFFFF);
    send_request(MODE_LOAD, 28'd65535, 7'd0, 28'd0);
    send_request(MODE_LOAD, 28'd65536, 7'd0, 28'd7);
    send_request(MODE_ALLOC, 28'd0, 7'd0, 28'd0);
    send_request(MODE_ALLOC, 28'd0, 7'd65, 28'd0);
    send_request(MODE_ALLOC, 28'd0, 7'd127, 28'd0);
    send_request(MODE_ALLOC, 28'd0, 7'd64, 28'd0);
    send_request(MODE_ALLOC, 28'd0, 7'd1, 28'd0);
    send_request(MODE_NEXT, 28'd2, 7'd0, 28'd0);
    send_request(MODE_FREE, 28'd2, 7'd0, 28'd0);
    send_request(MODE_FREE, 28'd0, 7'd0, 28'd0);
    send_request(MODE_FREE, 28'd1, 7'd0, 28'd0);
    send_request(MODE_FREE, 28'hFFFFFF8, 7'd0, 28'd0);
    send_request(MODE_FREE, 28'hFFFFFFF, 7'd0, 28'd0);
    send_request(MODE_LOAD, 28'd10, 7'd0, 28'd70000);
    send_request(MODE_FREE, 28'd10, 7'd0, 28'd0);
    send_request(MODE_LOAD, 28'd20, 7'd0, 28'd21);
    send_request(MODE_LOAD, 28'd21, 7'd0, 28'd20);
    send_request(MODE_FREE, 28'd20, 7'd0, 28'd0);

    // Tiny limits: nothing can be allocated
    write_reg(3'd0, 32'd1);
    send_request(MODE_ALLOC, 28'd0, 7'd1, 28'd0);
    send_request(MODE_NEXT, 28'd0, 7'd0, 28'd0);
    write_reg(3'd0, 32'd0);
    send_request(MODE_NEXT, 28'd0, 7'd0, 28'd0);
    write_reg(3'd0, 32'd2);
    send_request(MODE_ALLOC, 28'd0, 7'd1, 28'd0);
    send_request(MODE_LOAD, 28'd1, 7'd0, 28'd3);
    // Index beyond the register list is ignored
    write_reg(3'd4, 32'd50);
    send_request(MODE_NEXT, 28'd2, 7'd0, 28'd0);

    // Small table: frequent space exhaustion and broken chains
    write_reg(3'd0, 32'd40);
    for (int i = 0; i < 100; i++) begin
      if (i == 30) hold_cycles = 400;
      if (i == 60) drain();
      no_idle = (i >= 70 && i < 95);
      send_random();
    end
    no_idle = 1'b0;

    write_reg(3'd0, 32'd300);
    for (int i = 0; i < 150; i++) send_random();

    // Limit above the table size caps at the table
    write_reg(3'd0, 32'h0001FFFF);
    for (int i = 0; i < 35; i++) send_random();
    write_reg(3'd0, 32'd65536);
    for (int i = 0; i < 10; i++) send_random();

    drain();
    repeat (50) @(posedge clk);
    $display("Sent %0d requests over limits 0 to 65536, checked %0d result words.",
             requests_sent, words_seen);
    $display("Covered lookups, loads, chain frees and allocations with stalls.");
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
